// ----- hw/rtl/ost_pkg.sv -----
// Shared types and codes for the ordered set table.
`default_nettype none

package ost_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]                 opcode;
        logic signed [VALUE_W-1:0]  value;
    } in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
        logic             is_member;
        logic [POS_W-1:0] element_count;
    } out_t;

    // Store port controls driven by the sequencer.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_head;   // write the key instead of the last read word
    } store_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ost_store.sv -----
// Entry memory with registered read port and the shared equality comparator.
`default_nettype none

module ost_store #(
    parameter int CAPACITY = ost_pkg::CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  wire                                 clk,
    input  ost_pkg::store_ctl_t                 ctl,
    input  wire [IDX_W-1:0]                     rd_addr,
    input  wire [IDX_W-1:0]                     wr_addr,
    input  wire logic signed [ost_pkg::VALUE_W-1:0] key,
    output logic                                match
);
    import ost_pkg::*;

    logic signed [VALUE_W-1:0] mem [CAPACITY];
    logic signed [VALUE_W-1:0] rdata_reg;
    logic signed [VALUE_W-1:0] wdata;

    assign wdata = ctl.wr_head ? key : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign match = (rdata_reg == key);

endmodule

`default_nettype wire

// ----- hw/rtl/ordered_set_table.sv -----
// Top level: sequencer for a bounded newest-first set of signed 32-bit values.
//
// Command channel: cmd (opcode, value) is taken at a clock edge with start high
// and busy low. One result per command appears on result for exactly one
// cycle, marked by done; the receiver takes it at the edge ending that cycle
// and cannot hold it off. A new command may be taken during the done cycle.
//
// Steps, with n entries held and the match at 0-based index k:
//   scan: each entry read is followed by a compare of the read word with
//         the key, from index 0 until a hit at k or a miss after all n;
//   decide; then insert: n shifts (read, then write) plus one head write;
//   remove: n-k-1 shifts toward the head; last, the done state.
// Each shift first reads a word into the read register of the entry memory,
// then writes that word back one place along.
//
// Reset clears the element count and the sequencer; the entry memory is not
// cleared since only entries below the count are ever read.
`default_nettype none

module ordered_set_table #(
    parameter int CAPACITY = ost_pkg::CAPACITY_DEF
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    output logic           busy,
    input  ost_pkg::in_t   cmd,
    output logic           done,
    output ost_pkg::out_t  result
);
    import ost_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_CMP = 3'd2;
    localparam logic [2:0] S_DECIDE   = 3'd3;
    localparam logic [2:0] S_SHIFT_RD = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;
    localparam logic [2:0] S_HEAD_WR  = 3'd6;
    localparam logic [2:0] S_RESP     = 3'd7;

    logic [2:0]                state_reg,  state_next;
    logic [1:0]                op_reg,     op_next;
    logic signed [VALUE_W-1:0] value_reg,  value_next;
    logic [IDX_W-1:0]          idx_reg,    idx_next;
    logic                      found_reg,  found_next;
    logic [1:0]                status_reg, status_next;
    logic [CNT_W-1:0]          count_reg,  count_next;
    logic [CNT_W-1:0]          ptr_reg,    ptr_next;

    store_ctl_t       ctl;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             match;
    logic             accept;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] ptr_inc;
    logic [CNT_W-1:0] ptr_dec;

    assign busy    = (state_reg != S_IDLE) && (state_reg != S_RESP);
    assign accept  = start && !busy;
    assign idx_inc = CNT_W'(idx_reg) + CNT_W'(1);
    assign ptr_inc = ptr_reg + CNT_W'(1);
    assign ptr_dec = ptr_reg - CNT_W'(1);

    ost_store #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_store (
        .clk     (clk),
        .ctl     (ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .key     (value_reg),
        .match   (match)
    );

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        value_next  = value_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        status_next = status_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        ctl         = '0;
        rd_addr     = idx_reg;
        wr_addr     = ptr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE, S_RESP:
            begin
                if (state_reg == S_RESP)
                begin
                    state_next = S_IDLE;
                end
                if (accept)
                begin
                    op_next     = cmd.opcode;
                    value_next  = cmd.value;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    status_next = ST_OK;
                    state_next  = (count_reg == '0) ? S_DECIDE : S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                ctl.rd_en  = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                    state_next = S_DECIDE;
                end
                else if (idx_inc == count_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next   = idx_inc[IDX_W-1:0];
                    state_next = S_SCAN_RD;
                end
            end
            S_DECIDE:
            begin
                state_next = S_RESP;
                if (op_reg == OP_INSERT)
                begin
                    if (found_reg)
                    begin
                        status_next = ST_DUPLICATE;
                    end
                    else if (count_reg == CNT_W'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ptr_next   = count_reg;
                        state_next = (count_reg == '0) ? S_HEAD_WR : S_SHIFT_RD;
                    end
                end
                else if (op_reg == OP_REMOVE && found_reg)
                begin
                    ptr_next = CNT_W'(idx_reg);
                    if (idx_inc < count_reg)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            S_SHIFT_RD:
            begin
                // insert moves entries toward the tail, remove toward the head
                ctl.rd_en  = 1'b1;
                rd_addr    = (op_reg == OP_INSERT) ? ptr_dec[IDX_W-1:0] : ptr_inc[IDX_W-1:0];
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                ctl.wr_en = 1'b1;
                wr_addr   = ptr_reg[IDX_W-1:0];
                if (op_reg == OP_INSERT)
                begin
                    ptr_next   = ptr_dec;
                    state_next = (ptr_dec == '0) ? S_HEAD_WR : S_SHIFT_RD;
                end
                else
                begin
                    ptr_next = ptr_inc;
                    if (ptr_inc + CNT_W'(1) == count_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SHIFT_RD;
                    end
                end
            end
            S_HEAD_WR:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_head = 1'b1;
                wr_addr     = '0;
                count_next  = count_reg + CNT_W'(1);
                state_next  = S_RESP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        value_reg  <= value_next;
        idx_reg    <= idx_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        ptr_reg    <= ptr_next;
    end

    assign done                 = (state_reg == S_RESP);
    assign result.status        = status_reg;
    assign result.position      = found_reg ? POS_W'(idx_inc) : '0;
    assign result.is_member     = found_reg;
    assign result.element_count = POS_W'(count_reg);

endmodule

`default_nettype wire

// ----- verif/ordered_set_table_tb.sv -----
// Self-checking testbench for the ordered set table: queued commands checked against a predictor.
module ordered_set_table_tb;
    import ost_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int POOL_N = 24;
    localparam int PHASE_ITEMS = 633;
    // worst command is a successful insert into a nearly full store
    localparam int SETTLE_CYCLES = 4 * CAPACITY + 16;

    localparam logic [VALUE_W-1:0] V_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] V_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] V_NEG1 = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] V_ZERO = 32'h0000_0000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    in_t  cmd;
    out_t result;

    in_t  pending_cmds[$];
    out_t expected_results[$];

    // predictor copy of the store, newest at index 0
    logic [VALUE_W-1:0] held_values[CAPACITY];
    int                 held_count;

    logic [VALUE_W-1:0] value_pool[POOL_N];
    int                 gap_pct;
    int                 fail_count;
    logic               taken;

    ordered_set_table #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_500_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Applies one command to the predicted store and returns the answer it should give.
    function automatic out_t apply_table_op(in_t c);
        out_t r;
        int   idx;
        logic hit;
        idx = held_count;
        for (int i = 0; i < held_count; i++)
        begin
            if (held_values[i] == c.value && idx == held_count)
                idx = i;
        end
        hit = (idx < held_count);
        r.status = ST_OK;
        r.position = hit ? POS_W'(idx + 1) : '0;
        r.is_member = hit;
        case (c.opcode)
            OP_INSERT:
            begin
                if (hit)
                    r.status = ST_DUPLICATE;
                else if (held_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = held_count; i > 0; i--)
                        held_values[i] = held_values[i - 1];
                    held_values[0] = c.value;
                    held_count++;
                end
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    for (int i = idx; i + 1 < held_count; i++)
                        held_values[i] = held_values[i + 1];
                    held_count--;
                end
            end
            default:
            begin
            end
        endcase
        r.element_count = POS_W'(held_count);
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // driver: new transfer offered only once the previous one was taken
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || taken)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct)
            begin
                cmd <= pending_cmds.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: check results first, then predict the command taken at this edge
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no command outstanding: %p", result);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", 8'(want.status), 8'(result.status));
                    check_field("position", 8'(want.position), 8'(result.position));
                    check_field("is_member", 8'(want.is_member), 8'(result.is_member));
                    check_field("element_count", 8'(want.element_count),
                                8'(result.element_count));
                end
            end
            taken <= start && !busy;
            if (start && !busy)
                expected_results.push_back(apply_table_op(cmd));
        end
    end

    task automatic push_cmd(logic [1:0] op, logic [VALUE_W-1:0] v);
        in_t c;
        c.opcode = op;
        c.value = v;
        pending_cmds.push_back(c);
    endtask

    // sampled at the rising edge, where start and the command queue are settled
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return value_pool[$urandom_range(POOL_N - 1)];
        else if (r < 88 && held_count > 0)
            return held_values[$urandom_range(held_count - 1)];
        return $urandom;
    endfunction

    task automatic refresh_pool();
        int slot;
        for (int k = 0; k < 3; k++)
        begin
            slot = $urandom_range(POOL_N - 1);
            if ($urandom_range(7) == 0)
            begin
                case ($urandom_range(3))
                    0: value_pool[slot] = V_MIN;
                    1: value_pool[slot] = V_MAX;
                    2: value_pool[slot] = V_NEG1;
                    default: value_pool[slot] = V_ZERO;
                endcase
            end
            else
                value_pool[slot] = $urandom;
        end
    endtask

    // mix: 0 fills the store, 1 balanced, 2 empties it, 3 pure noise
    task automatic queue_chunk(int mix, int n);
        int ins_lim;
        int rm_lim;
        int r;
        ins_lim = (mix == 0) ? 70 : (mix == 1) ? 40 : 15;
        rm_lim = (mix == 0) ? 80 : (mix == 1) ? 70 : 80;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (mix == 3)
                push_cmd(2'($urandom_range(3)), $urandom);
            else if (r < ins_lim)
                push_cmd(OP_INSERT, pick_value());
            else if (r < rm_lim)
                push_cmd(OP_REMOVE, pick_value());
            else if (r < 95)
                push_cmd(OP_QUERY, pick_value());
            else
                push_cmd(OP_UNUSED, pick_value());
        end
    endtask

    initial
    begin
        int phase_items;
        int n;
        int r;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        taken = 1'b0;
        held_count = 0;
        fail_count = 0;
        gap_pct = 8;
        for (int k = 0; k < POOL_N; k++)
            value_pool[k] = $urandom;
        value_pool[0] = V_MIN;
        value_pool[1] = V_MAX;
        value_pool[2] = V_NEG1;
        value_pool[3] = V_ZERO;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty store, extremes, duplicate, unused opcode, middle removal
        push_cmd(OP_QUERY, V_ZERO);
        push_cmd(OP_REMOVE, V_ZERO);
        push_cmd(OP_INSERT, V_MIN);
        push_cmd(OP_INSERT, V_MAX);
        push_cmd(OP_INSERT, V_NEG1);
        push_cmd(OP_INSERT, V_ZERO);
        push_cmd(OP_INSERT, V_MAX);
        push_cmd(OP_QUERY, V_MIN);
        push_cmd(OP_UNUSED, V_MAX);
        push_cmd(OP_REMOVE, V_NEG1);
        // fill to capacity, then refused inserts: new value, and duplicate while full
        for (int k = 1; k <= CAPACITY - 3; k++)
            push_cmd(OP_INSERT, k);
        push_cmd(OP_INSERT, 32'd100);
        push_cmd(OP_INSERT, V_ZERO);
        push_cmd(OP_QUERY, V_MIN);
        push_cmd(OP_REMOVE, V_MIN);
        push_cmd(OP_REMOVE, CAPACITY - 3);
        wait_idle();

        for (int phase = 0; phase < 3; phase++)
        begin
            gap_pct = (phase == 0) ? 8 : (phase == 1) ? 51 : 0;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                n = $urandom_range(20, 60);
                r = $urandom_range(9);
                refresh_pool();
                queue_chunk((r < 3) ? 0 : (r < 6) ? 1 : (r < 9) ? 2 : 3, n);
                phase_items += n;
                // sender holds off until every outstanding result is back
                wait_idle();
            end
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && expected_results.size() == 0 && pending_cmds.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
